// ===== hdl/sha1sh_pkg.sv =====
// Constants shared by the SHA-1 stream hasher: initial chaining value, round constants, padding.
package sha1sh_pkg;

   // Initial chaining value. Index 0 holds the first digest word.
   localparam logic [4:0][31:0] H_INIT = {
      32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
   };

   // Round constants, one per group of twenty rounds.
   localparam logic [31:0] K_GROUP0 = 32'h5a827999;
   localparam logic [31:0] K_GROUP1 = 32'h6ed9eba1;
   localparam logic [31:0] K_GROUP2 = 32'h8f1bbcdc;
   localparam logic [31:0] K_GROUP3 = 32'hca62c1d6;

   // Round group boundaries and the last round index.
   localparam logic [6:0] GROUP1_START = 7'd20;
   localparam logic [6:0] GROUP2_START = 7'd40;
   localparam logic [6:0] GROUP3_START = 7'd60;
   localparam logic [6:0] LAST_ROUND   = 7'd79;

   // Padding: the end marker byte, the first byte position of the length
   // field, and the last byte position of a block.
   localparam logic [7:0] PAD_MARK        = 8'h80;
   localparam logic [5:0] LEN_FIELD_START = 6'd56;
   localparam logic [5:0] LAST_BYTE_POS   = 6'd63;

endpackage

// ===== hdl/sha1_stream_hasher.sv =====
// SHA-1 stream hasher: byte intake, padding sequencer and one shared round unit.
// Intake: a byte that leaves the block unfilled is taken without a stall; a byte that completes a block
// holds intake off through the rounds and the chaining add. An end beat pads the current block and
// compresses it, plus an extra block when the length field does not fit; the digest then waits for
// a free output register. No new byte is taken while a block is padded or compressed.
// Reset (synchronous): chaining value to the initial constants, counts and flags to zero.
module sha1_stream_hasher
   import sha1sh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word0,
   output logic [31:0] rsp_digest_word1,
   output logic [31:0] rsp_digest_word2,
   output logic [31:0] rsp_digest_word3,
   output logic [31:0] rsp_digest_word4,
   output logic        rsp_length_overflow
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_ADDH,
      ST_PAD,
      ST_OUTPUT
   } state_type;

   // Sequencer state and control.
   state_type        state_ff, state_in;
   logic [6:0]       round_ff, round_in;
   logic [5:0]       fill_ff, fill_in;
   logic [63:0]      len_ff, len_in;
   logic             ovf_ff, ovf_in;
   // The end marker byte has been placed in the current message.
   logic             mark_ff, mark_in;
   // The current padded block carries the length field in its last eight bytes.
   logic             len_ok_ff, len_ok_in;
   // The message end has been seen and padding is still owed.
   logic             last_ff, last_in;
   // The compression in flight is the final one of the message.
   logic             final_ff, final_in;
   logic [4:0][31:0] h_ff, h_in;

   // Datapath: working variables a..e in index 0..4, and the 512-bit block
   // buffer. The buffer takes bytes by shifting left one byte at a time, so
   // a full block holds its first byte in the top bits. During the rounds
   // the same register acts as the sixteen-word schedule window: word 0 is
   // the current schedule word, and each round shifts in the next one.
   logic [4:0][31:0] work_ff, work_in;
   logic [511:0]     sched_ff, sched_in;

   // Output register. It holds a finished digest until the beat is taken.
   logic             rsp_valid_ff, rsp_valid_in;
   logic [4:0][31:0] dig_ff, dig_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   logic [64:0] len_sum;
   logic [31:0] w_cur;
   logic [31:0] w_mix;
   logic [31:0] w_next;
   logic [31:0] f_val;
   logic [31:0] k_val;
   logic [31:0] t_val;
   logic [7:0]  pad_byte;

   // Bit count plus one byte; the carry out marks a length wrap.
   assign len_sum = {1'b0, len_ff} + 65'd8;

   // Schedule taps: the new word is W[i+16] from W[i+13], W[i+8], W[i+2], W[i].
   assign w_cur  = sched_ff[511:480];
   assign w_mix  = sched_ff[95:64] ^ sched_ff[255:224] ^ sched_ff[447:416] ^ w_cur;
   assign w_next = {w_mix[30:0], w_mix[31]};

   // Round function and constant by group of twenty rounds.
   always_comb begin
      if (round_ff < GROUP1_START) begin
         f_val = (work_ff[1] & work_ff[2]) | (~work_ff[1] & work_ff[3]);
         k_val = K_GROUP0;
      end else if (round_ff < GROUP2_START) begin
         f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
         k_val = K_GROUP1;
      end else if (round_ff < GROUP3_START) begin
         f_val = (work_ff[1] & work_ff[2]) | (work_ff[1] & work_ff[3]) |
                 (work_ff[2] & work_ff[3]);
         k_val = K_GROUP2;
      end else begin
         f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
         k_val = K_GROUP3;
      end
   end

   assign t_val = {work_ff[0][26:0], work_ff[0][31:27]} + f_val + work_ff[4] + w_cur + k_val;

   // Padding byte for the current buffer position: the end marker first, then
   // zeros, and in the block that carries it the big-endian bit count.
   always_comb begin
      if (!mark_ff) begin
         pad_byte = PAD_MARK;
      end else if (len_ok_ff && (fill_ff >= LEN_FIELD_START)) begin
         pad_byte = len_ff[{~fill_ff[2:0], 3'b000} +: 8];
      end else begin
         pad_byte = 8'h00;
      end
   end

   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      fill_in      = fill_ff;
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      mark_in      = mark_ff;
      len_ok_in    = len_ok_ff;
      last_in      = last_ff;
      final_in     = final_ff;
      h_in         = h_ff;
      work_in      = work_ff;
      sched_in     = sched_ff;
      rsp_valid_in = rsp_valid_ff;
      dig_in       = dig_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      // A waiting digest leaves when the receiver takes the beat.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_has_byte) begin
                  sched_in = {sched_ff[503:0], req_data_byte};
                  fill_in  = fill_ff + 6'd1;
                  len_in   = len_sum[63:0];
                  if (len_sum[64]) begin
                     ovf_in = 1'b1;
                  end
               end
               last_in = req_last;
               // A byte in the last position completes the block: compress
               // it first, then pad if the beat also ends the message.
               if (req_has_byte && (fill_ff == LAST_BYTE_POS)) begin
                  state_in = ST_ROUND;
                  round_in = 7'd0;
                  work_in  = h_ff;
                  final_in = 1'b0;
               end else if (req_last) begin
                  state_in = ST_PAD;
               end
            end
         end

         ST_ROUND: begin
            work_in[0] = t_val;
            work_in[1] = work_ff[0];
            work_in[2] = {work_ff[1][1:0], work_ff[1][31:2]};
            work_in[3] = work_ff[2];
            work_in[4] = work_ff[3];
            sched_in   = {sched_ff[479:0], w_next};
            round_in   = round_ff + 7'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_ADDH;
            end
         end

         ST_ADDH: begin
            for (int i = 0; i < 5; i++) begin
               h_in[i] = h_ff[i] + work_ff[i];
            end
            if (final_ff) begin
               state_in = ST_OUTPUT;
            end else if (last_ff) begin
               // The block after an overflowing pad block carries the length.
               len_ok_in = 1'b1;
               state_in  = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_PAD: begin
            sched_in = {sched_ff[503:0], pad_byte};
            fill_in  = fill_ff + 6'd1;
            if (!mark_ff) begin
               mark_in   = 1'b1;
               len_ok_in = (fill_ff < LEN_FIELD_START);
            end
            if (fill_ff == LAST_BYTE_POS) begin
               state_in = ST_ROUND;
               round_in = 7'd0;
               work_in  = h_ff;
               final_in = mark_ff && len_ok_ff;
            end
         end

         ST_OUTPUT: begin
            // Hand the digest over once the output register is free, and
            // start the next message from the initial chaining value.
            if (!rsp_valid_ff || !rsp_stall) begin
               dig_in       = h_ff;
               rsp_ovf_in   = ovf_ff;
               rsp_valid_in = 1'b1;
               h_in         = H_INIT;
               fill_in      = 6'd0;
               len_in       = 64'd0;
               ovf_in       = 1'b0;
               mark_in      = 1'b0;
               len_ok_in    = 1'b0;
               last_in      = 1'b0;
               final_in     = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= 7'd0;
         fill_ff      <= 6'd0;
         len_ff       <= 64'd0;
         ovf_ff       <= 1'b0;
         mark_ff      <= 1'b0;
         len_ok_ff    <= 1'b0;
         last_ff      <= 1'b0;
         final_ff     <= 1'b0;
         h_ff         <= H_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         fill_ff      <= fill_in;
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         mark_ff      <= mark_in;
         len_ok_ff    <= len_ok_in;
         last_ff      <= last_in;
         final_ff     <= final_in;
         h_ff         <= h_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      work_ff    <= work_in;
      sched_ff   <= sched_in;
      dig_ff     <= dig_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   // Input beats are taken only while the sequencer waits for the next byte.
   assign req_stall = (state_ff != ST_IDLE);

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_digest_word0    = dig_ff[0];
   assign rsp_digest_word1    = dig_ff[1];
   assign rsp_digest_word2    = dig_ff[2];
   assign rsp_digest_word3    = dig_ff[3];
   assign rsp_digest_word4    = dig_ff[4];
   assign rsp_length_overflow = rsp_ovf_ff;

endmodule
